// ----- design/mlas_pkg.sv -----
// Shared types, codes and the microprogram of the list append, search and remove core.
package mlas_pkg;

  // Field widths of the command and response words
  localparam int OP_W     = 2;
  localparam int OWNER_W  = 5;
  localparam int CAT_W    = 2;
  localparam int ITEM_W   = 16;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;

  // Default sizing handed to the top level
  localparam int OWNERS_DEF     = 16;
  localparam int CATEGORIES_DEF = 4;
  localparam int SLOTS_DEF      = 16;
  localparam int VALUE_BITS_DEF = 16;

  // Command codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  localparam logic [POS_W-1:0] NO_POS = 5'h1F;

  // Microprogram step addresses
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_CLEAR    = 5'd0;
  localparam logic [STEP_W-1:0] S_IDLE     = 5'd1;
  localparam logic [STEP_W-1:0] S_LREAD    = 5'd2;
  localparam logic [STEP_W-1:0] S_COUNT    = 5'd3;
  localparam logic [STEP_W-1:0] S_DISPATCH = 5'd4;
  localparam logic [STEP_W-1:0] S_APPEND   = 5'd5;
  localparam logic [STEP_W-1:0] S_APP_WR   = 5'd6;
  localparam logic [STEP_W-1:0] S_FULL     = 5'd7;
  localparam logic [STEP_W-1:0] S_F_INIT   = 5'd8;
  localparam logic [STEP_W-1:0] S_F_PRIME  = 5'd9;
  localparam logic [STEP_W-1:0] S_F_LOOP   = 5'd10;
  localparam logic [STEP_W-1:0] S_F_END    = 5'd11;
  localparam logic [STEP_W-1:0] S_FOUND    = 5'd12;
  localparam logic [STEP_W-1:0] S_RM_INIT  = 5'd13;
  localparam logic [STEP_W-1:0] S_RM_PRIME = 5'd14;
  localparam logic [STEP_W-1:0] S_RM_LOOP  = 5'd15;
  localparam logic [STEP_W-1:0] S_RM_END   = 5'd16;
  localparam logic [STEP_W-1:0] S_DONE     = 5'd17;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_INC_NT,
    IDX_POS_P1
  } idx_op_t;

  typedef enum logic [1:0] {
    LEN_ZERO,
    LEN_INC,
    LEN_DEC
  } len_op_t;

  typedef enum logic [1:0] {
    ST_KEEP,
    ST_OK,
    ST_FULL
  } st_op_t;

  typedef enum logic {
    WS_APPEND,
    WS_SHIFT
  } wsel_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_FIRE,
    C_LAST_LIST,
    C_FULL,
    C_CNT_ZERO,
    C_IDX_EQ_CNT,
    C_STOP,
    C_HIT,
    C_OUT_FREE
  } cond_t;

  typedef enum logic {
    NXT_BRANCH,
    NXT_DISPATCH
  } nxt_t;

  // One control word of the microprogram
  typedef struct packed {
    logic              in_ready;
    logic              cnt_load;
    logic              store_we;
    wsel_t             wsel;
    logic              len_we;
    len_op_t           len_op;
    idx_op_t           idx_op;
    logic              hit_cap;
    st_op_t            st_op;
    logic              fpos_set;
    logic              out_load;
    cond_t             cond;
    nxt_t              mode;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
  } ctl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic            cmd_valid;
    logic            out_free;
    logic            last_list;
    logic            full;
    logic            cnt_zero;
    logic            idx_eq_cnt;
    logic            stop;
    logic            hit;
    logic [OP_W-1:0] op;
    logic            cmd_ok;
    logic            rm_ok;
  } flags_t;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    c        = '0;
    c.cond   = C_ALWAYS;
    c.mode   = NXT_BRANCH;
    c.tgt_t  = S_IDLE;
    c.tgt_f  = S_IDLE;
    case (step)
      S_CLEAR: begin
        c.len_we = 1'b1;
        c.len_op = LEN_ZERO;
        c.idx_op = IDX_INC;
        c.cond   = C_LAST_LIST;
        c.tgt_t  = S_IDLE;
        c.tgt_f  = S_CLEAR;
      end
      S_IDLE: begin
        c.in_ready = 1'b1;
        c.cond     = C_IN_FIRE;
        c.tgt_t    = S_LREAD;
        c.tgt_f    = S_IDLE;
      end
      S_LREAD: begin
        c.tgt_t = S_COUNT;
      end
      S_COUNT: begin
        c.cnt_load = 1'b1;
        c.tgt_t    = S_DISPATCH;
      end
      S_DISPATCH: begin
        c.mode = NXT_DISPATCH;
      end
      S_APPEND: begin
        c.cond  = C_FULL;
        c.tgt_t = S_FULL;
        c.tgt_f = S_APP_WR;
      end
      S_APP_WR: begin
        c.store_we = 1'b1;
        c.wsel     = WS_APPEND;
        c.len_we   = 1'b1;
        c.len_op   = LEN_INC;
        c.tgt_t    = S_DONE;
      end
      S_FULL: begin
        c.st_op = ST_FULL;
        c.tgt_t = S_DONE;
      end
      S_F_INIT: begin
        c.idx_op = IDX_ZERO;
        c.cond   = C_CNT_ZERO;
        c.tgt_t  = S_DONE;
        c.tgt_f  = S_F_PRIME;
      end
      S_F_PRIME: begin
        c.idx_op = IDX_INC;
        c.tgt_t  = S_F_LOOP;
      end
      S_F_LOOP: begin
        c.hit_cap = 1'b1;
        c.idx_op  = IDX_INC_NT;
        c.cond    = C_STOP;
        c.tgt_t   = S_F_END;
        c.tgt_f   = S_F_LOOP;
      end
      S_F_END: begin
        c.cond  = C_HIT;
        c.tgt_t = S_FOUND;
        c.tgt_f = S_DONE;
      end
      S_FOUND: begin
        c.st_op    = ST_OK;
        c.fpos_set = 1'b1;
        c.tgt_t    = S_DONE;
      end
      S_RM_INIT: begin
        c.idx_op = IDX_POS_P1;
        c.tgt_t  = S_RM_PRIME;
      end
      S_RM_PRIME: begin
        c.idx_op = IDX_INC_NT;
        c.cond   = C_IDX_EQ_CNT;
        c.tgt_t  = S_RM_END;
        c.tgt_f  = S_RM_LOOP;
      end
      S_RM_LOOP: begin
        c.store_we = 1'b1;
        c.wsel     = WS_SHIFT;
        c.idx_op   = IDX_INC_NT;
        c.cond     = C_IDX_EQ_CNT;
        c.tgt_t    = S_RM_END;
        c.tgt_f    = S_RM_LOOP;
      end
      S_RM_END: begin
        c.len_we = 1'b1;
        c.len_op = LEN_DEC;
        c.st_op  = ST_OK;
        c.tgt_t  = S_DONE;
      end
      S_DONE: begin
        c.out_load = 1'b1;
        c.cond     = C_OUT_FREE;
        c.tgt_t    = S_IDLE;
        c.tgt_f    = S_DONE;
      end
      default: begin
        c.tgt_t = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- design/mlas_if.sv -----
// Command and response channel interfaces of the list core.
interface mlas_cmd_if;
  import mlas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [OWNER_W-1:0]       owner_id;
  logic                     owner_present;
  logic [CAT_W-1:0]         category;
  logic [ITEM_W-1:0]        item_value;
  logic signed [POS_W-1:0]  position;

  modport source (
    output valid, op, owner_id, owner_present, category, item_value, position,
    input  ready
  );
  modport sink (
    input  valid, op, owner_id, owner_present, category, item_value, position,
    output ready
  );
endinterface

interface mlas_rsp_if;
  import mlas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [POS_W-1:0]  found_position;

  modport source (
    output valid, status, found_position,
    input  ready
  );
  modport sink (
    input  valid, status, found_position,
    output ready
  );
endinterface

// ----- design/mlas_seq.sv -----
// Microcode sequencer: step counter, control store and branch logic.
module mlas_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  mlas_pkg::flags_t             flags,
  output mlas_pkg::ctl_t               ctl,
  output logic                         taken,
  output logic [mlas_pkg::STEP_W-1:0]  upc
);
  import mlas_pkg::*;

  logic [STEP_W-1:0] upc_next;
  logic [STEP_W-1:0] disp_tgt;

  always_comb ctl = ucode(upc);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:     taken = 1'b1;
      C_IN_FIRE:    taken = flags.cmd_valid;
      C_LAST_LIST:  taken = flags.last_list;
      C_FULL:       taken = flags.full;
      C_CNT_ZERO:   taken = flags.cnt_zero;
      C_IDX_EQ_CNT: taken = flags.idx_eq_cnt;
      C_STOP:       taken = flags.stop;
      C_HIT:        taken = flags.hit;
      C_OUT_FREE:   taken = flags.out_free;
      default:      taken = 1'b1;
    endcase
  end

  // Jump by command; bad owner, category, op or remove position goes to the answer
  always_comb begin
    if (!flags.cmd_ok) begin
      disp_tgt = S_DONE;
    end else begin
      case (flags.op)
        OP_APPEND: disp_tgt = S_APPEND;
        OP_FIND:   disp_tgt = S_F_INIT;
        OP_REMOVE: disp_tgt = flags.rm_ok ? S_RM_INIT : S_DONE;
        default:   disp_tgt = S_DONE;
      endcase
    end
  end

  always_comb begin
    if (ctl.mode == NXT_DISPATCH) begin
      upc_next = disp_tgt;
    end else begin
      upc_next = taken ? ctl.tgt_t : ctl.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ----- design/mlas_dp.sv -----
// Datapath: command capture, count and item memories, index counter, response register.
module mlas_dp #(
  parameter int OWNERS     = mlas_pkg::OWNERS_DEF,
  parameter int CATEGORIES = mlas_pkg::CATEGORIES_DEF,
  parameter int SLOTS      = mlas_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = mlas_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mlas_pkg::ctl_t    ctl,
  input  logic              taken,
  output mlas_pkg::flags_t  flags,
  mlas_cmd_if.sink          cmd,
  mlas_rsp_if.source        rsp
);
  import mlas_pkg::*;

  localparam int LISTS  = OWNERS * CATEGORIES;
  localparam int DEPTH  = LISTS * SLOTS;
  localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int IDX_MAX = ((LISTS - 1) > SLOTS) ? (LISTS - 1) : SLOTS;
  localparam int IDX_W  = $clog2(IDX_MAX + 1);

  // Captured command
  logic [OP_W-1:0]        op;
  logic                   cmd_ok;
  logic [LIST_W-1:0]      list;
  logic [VALUE_BITS-1:0]  val;
  logic [POS_W-1:0]       pos;

  logic [CNT_W-1:0]       len_q;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       idx;
  logic                   hit;
  logic [STATUS_W-1:0]    res_status;
  logic [POS_W-1:0]       res_fpos;

  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [POS_W-1:0]       out_fpos;

  logic [CNT_W-1:0]       len_mem [LISTS];
  logic [VALUE_BITS-1:0]  store_mem [DEPTH];
  logic [VALUE_BITS-1:0]  rd_q;

  logic                   in_fire;
  logic                   ok_in;
  logic [LIST_W-1:0]      list_in;
  logic [VALUE_BITS-1:0]  val_in;
  logic [LIST_W-1:0]      len_waddr;
  logic [CNT_W-1:0]       len_wdata;
  logic [ADDR_W-1:0]      base;
  logic [ADDR_W-1:0]      raddr;
  logic [ADDR_W-1:0]      waddr;
  logic [VALUE_BITS-1:0]  wdata;
  logic [IDX_W-1:0]       wslot;
  logic                   out_free;
  logic                   match;

  assign cmd.ready = ctl.in_ready;
  assign in_fire   = cmd.valid && ctl.in_ready;

  assign ok_in   = cmd.owner_present && (cmd.owner_id != '0)
                   && (32'(cmd.owner_id) <= OWNERS) && (32'(cmd.category) < CATEGORIES);
  assign list_in = LIST_W'((32'(cmd.owner_id) - 32'd1) * CATEGORIES + 32'(cmd.category));
  assign val_in  = VALUE_BITS'(cmd.item_value);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op     <= cmd.op;
      cmd_ok <= ok_in;
      list   <= list_in;
      val    <= val_in;
      pos    <= cmd.position;
    end
  end

  // Count memory: written by the clearing pass and at the end of append and remove
  always_comb begin
    case (ctl.len_op)
      LEN_ZERO: begin
        len_waddr = LIST_W'(idx);
        len_wdata = '0;
      end
      LEN_INC: begin
        len_waddr = list;
        len_wdata = cnt + CNT_W'(1);
      end
      LEN_DEC: begin
        len_waddr = list;
        len_wdata = cnt - CNT_W'(1);
      end
      default: begin
        len_waddr = list;
        len_wdata = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_q <= len_mem[list];
  end

  always_ff @(posedge clk) begin
    if (ctl.cnt_load) begin
      cnt <= len_q;
    end
  end

  // Item memory: read at the index, write at the tail or two places below the read index
  assign base  = ADDR_W'(32'(list) * SLOTS);
  assign raddr = base + ADDR_W'(idx);
  assign wslot = (ctl.wsel == WS_APPEND) ? IDX_W'(cnt) : (idx - IDX_W'(2));
  assign waddr = base + ADDR_W'(wslot);
  assign wdata = (ctl.wsel == WS_APPEND) ? val : rd_q;

  always_ff @(posedge clk) begin
    if (ctl.store_we) begin
      store_mem[waddr] <= wdata;
    end
    rd_q <= store_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (ctl.idx_op)
        IDX_ZERO:   idx <= '0;
        IDX_INC:    idx <= idx + IDX_W'(1);
        IDX_INC_NT: if (!taken) idx <= idx + IDX_W'(1);
        IDX_POS_P1: idx <= IDX_W'(pos[POS_W-2:0]) + IDX_W'(1);
        default:    idx <= idx;
      endcase
    end
  end

  assign match = (rd_q == val);

  always_ff @(posedge clk) begin
    if (ctl.hit_cap) begin
      hit <= match;
    end
  end

  // Result being built; preset on capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_status <= (cmd.op == OP_APPEND) ? STATUS_OK : STATUS_MISS;
      res_fpos   <= NO_POS;
    end else begin
      case (ctl.st_op)
        ST_OK:   res_status <= STATUS_OK;
        ST_FULL: res_status <= STATUS_FULL;
        default: res_status <= res_status;
      endcase
      if (ctl.fpos_set) begin
        res_fpos <= POS_W'(idx - IDX_W'(1));
      end
    end
  end

  // Response register
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load && out_free) begin
      out_status <= res_status;
      out_fpos   <= res_fpos;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_fpos;

  always_comb begin
    flags.cmd_valid  = cmd.valid;
    flags.out_free   = out_free;
    flags.last_list  = (32'(idx) == LISTS - 1);
    flags.full       = (32'(cnt) >= SLOTS);
    flags.cnt_zero   = (cnt == '0);
    flags.idx_eq_cnt = (32'(idx) == 32'(cnt));
    flags.stop       = match || (32'(idx) == 32'(cnt));
    flags.hit        = hit;
    flags.op         = op;
    flags.cmd_ok     = cmd_ok;
    flags.rm_ok      = !pos[POS_W-1] && (32'(pos[POS_W-2:0]) < 32'(cnt));
  end

endmodule

// ----- design/multi_list_append_search_remove_core.sv -----
// Top level of the list core: per-owner, per-category lists with append, find and remove.
// One command word is taken at a time on cmd and answered by one response word on rsp.
// Every owner and category pair has a list of up to SLOTS values with its own count.
// Append stores the value at the tail or answers full; find walks the list from the
// head and answers the first matching position; remove drops one entry and shifts the
// later ones down. A command for an absent owner, an owner number out of range or a
// category out of range changes nothing (append then still answers ok). A microcoded
// sequencer steps a small datapath with one item memory (one read port, one write port),
// so the walk over the list reads one entry per cycle. A command that is turned away at
// dispatch (absent or out-of-range owner or category, undefined op, remove position
// negative or at or past the count) goes straight to the answer. The command port reopens
// in the cycle after the response word is loaded. After reset the count memory is cleared
// in a pass over all OWNERS*CATEGORIES lists, during which cmd.ready stays low.
// The response sits in an output register, so the next command is taken while the
// previous answer still waits; a second answer stalls in the sequencer until it drains.
module multi_list_append_search_remove_core #(
  parameter int OWNERS     = mlas_pkg::OWNERS_DEF,
  parameter int CATEGORIES = mlas_pkg::CATEGORIES_DEF,
  parameter int SLOTS      = mlas_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = mlas_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mlas_cmd_if.sink    cmd,
  mlas_rsp_if.source  rsp
);
  import mlas_pkg::*;

  ctl_t              ctl;
  flags_t            flags;
  logic              taken;
  logic [STEP_W-1:0] upc;

  // Sequencer: step counter and control store
  mlas_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl),
    .taken (taken),
    .upc   (upc)
  );

  // Datapath: memories, index counter, result and response registers
  mlas_dp #(
    .OWNERS     (OWNERS),
    .CATEGORIES (CATEGORIES),
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .taken (taken),
    .flags (flags),
    .cmd   (cmd),
    .rsp   (rsp)
  );

`ifndef SYNTHESIS
  // An accepted command word always starts its list-count read next
  a_accept_lread: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> upc == S_LREAD)
    else $error("accepted command did not advance to the count read");

  // A finished answer with room in the output register is shown next cycle
  a_answer_shown: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load && flags.out_free |=> rsp.valid)
    else $error("response word not presented after completion");

  // Never grow a list that is already full
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    ctl.len_we && ctl.len_op == LEN_INC |-> !flags.full)
    else $error("count raised on a full list");

  // No command is taken while the item memory is being written
  a_no_take_on_write: assert property (@(posedge clk) disable iff (rst)
    ctl.store_we |-> !cmd.ready)
    else $error("command port open during an item write");
`endif

endmodule

// ----- bench/multi_list_append_search_remove_core_tb.sv -----
// Self-checking testbench for the list append, search and remove core.
`timescale 1ns / 100ps

module multi_list_append_search_remove_core_tb;
  import mlas_pkg::*;

  // Sizing of the core under test; the predictor shares it
  localparam int OWNERS     = OWNERS_DEF;
  localparam int CATEGORIES = CATEGORIES_DEF;
  localparam int SLOTS      = SLOTS_DEF;
  localparam int LISTS      = OWNERS * CATEGORIES;

  // The one op code that the package leaves without a name
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  // One command word as offered on the cmd channel
  typedef struct {
    logic [OP_W-1:0]         op;
    logic [OWNER_W-1:0]      owner;
    logic                    present;
    logic [CAT_W-1:0]        cat;
    logic [ITEM_W-1:0]       value;
    logic signed [POS_W-1:0] pos;
  } list_cmd_t;

  // One response word as the lists should answer it
  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic signed [POS_W-1:0] found_position;
  } list_answer_t;

  logic clk;
  logic rst;

  mlas_cmd_if cmd_ch ();
  mlas_rsp_if rsp_ch ();

  multi_list_append_search_remove_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of every list: its values and its entry count
  logic [ITEM_W-1:0] list_vals  [LISTS][SLOTS];
  int                list_count [LISTS];

  // Answers owed by the core, oldest first
  list_answer_t pending_answers [$];
  list_answer_t want;

  int error_count;
  int cycle_count;
  bit idle_on;        // random gaps and stalls allowed
  bit hold_request;   // ask the receiver for one long hold-off
  int stall_left;
  int hot_list [4];   // lists that most random words address, so they fill and drain

  // Free-running clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: give up if the run goes on far past its slowest correct length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_list_append_search_remove_core_tb: FAIL");
      $finish;
    end
  end

  // Work out the answer to one accepted command and advance the shadow lists.
  // An owner that is absent or out of range, or a category out of range,
  // leaves every list untouched; append still answers ok in that case.
  function automatic list_answer_t predict_answer(input list_cmd_t c);
    list_answer_t a;
    bit           known;
    int           li;
    int           n;
    int           i;
    a.status         = STATUS_MISS;
    a.found_position = NO_POS;
    known = c.present && (c.owner >= 1) && (int'(c.owner) <= OWNERS)
            && (int'(c.cat) < CATEGORIES);
    li = known ? (int'(c.owner) - 1) * CATEGORIES + int'(c.cat) : 0;
    n  = list_count[li];
    case (c.op)
      OP_APPEND: begin
        a.status = STATUS_OK;
        if (known) begin
          if (n >= SLOTS) begin
            a.status = STATUS_FULL;
          end else begin
            list_vals[li][n] = c.value;
            list_count[li]   = n + 1;
          end
        end
      end
      OP_FIND: begin
        // walk down from the tail so that the lowest match is the one kept
        if (known) begin
          for (i = n - 1; i >= 0; i--) begin
            if (list_vals[li][i] == c.value) begin
              a.status         = STATUS_OK;
              a.found_position = POS_W'(i);
            end
          end
        end
      end
      OP_REMOVE: begin
        // reject a negative position and one at or past the count
        if (known && !c.pos[POS_W-1] && int'(c.pos) < n) begin
          for (i = int'(c.pos) + 1; i < n; i++) begin
            list_vals[li][i-1] = list_vals[li][i];
          end
          list_vals[li][n-1] = '0;
          list_count[li]     = n - 1;
          a.status           = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic list_cmd_t make_cmd(input logic [OP_W-1:0] op,
                                         input logic [OWNER_W-1:0] owner,
                                         input logic present,
                                         input logic [CAT_W-1:0] cat,
                                         input logic [ITEM_W-1:0] value,
                                         input logic signed [POS_W-1:0] pos);
    list_cmd_t c;
    c.op      = op;
    c.owner   = owner;
    c.present = present;
    c.cat     = cat;
    c.value   = value;
    c.pos     = pos;
    return c;
  endfunction

  // Offer one command word and hold it until the core takes it. The word is
  // driven at the falling edge; valid is assigned once per edge, so a word that
  // follows straight on keeps valid high without a glitch.
  task automatic send_cmd(input list_cmd_t c);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.op            <= c.op;
    cmd_ch.owner_id      <= c.owner;
    cmd_ch.owner_present <= c.present;
    cmd_ch.category      <= c.cat;
    cmd_ch.item_value    <= c.value;
    cmd_ch.position      <= c.pos;
    cmd_ch.valid         <= 1'b1;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    // commands are answered in order, so predict at the moment of acceptance
    pending_answers.push_back(predict_answer(c));
  endtask

  // Receiver: ready changes at the falling edge only. A long hold-off is
  // counted here, in cycles; otherwise stall in random bursts.
  initial begin
    rsp_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 9);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Checker: compare every response word taken with the oldest answer owed
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: response word with nothing pending: status %0d position %0d",
                 $time, rsp_ch.status, rsp_ch.found_position);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.found_position !== want.found_position) begin
          $display("%0t: found_position mismatch, expected %0d, got %0d",
                   $time, want.found_position, rsp_ch.found_position);
          error_count++;
        end
      end
    end
  end

  // Empty lists, edge values, absent and out-of-range owners, the undefined
  // op code and every way that remove can be rejected, then two good removes.
  task automatic test_edge_cases();
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b1, 2'd0, 16'h0000, 5'sd0));
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b1, 2'd0, 16'h0000, 5'sd0));
    send_cmd(make_cmd(OP_APPEND, 5'd1,  1'b1, 2'd0, 16'h0000, 5'sd0));
    send_cmd(make_cmd(OP_APPEND, 5'd1,  1'b1, 2'd0, 16'hFFFF, 5'sd0));
    send_cmd(make_cmd(OP_APPEND, 5'd1,  1'b1, 2'd0, 16'hFFFF, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b1, 2'd0, 16'hFFFF, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b1, 2'd0, 16'h0000, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b1, 2'd0, 16'h1234, 5'sd0));
    // absent owner: append answers ok yet stores nothing
    send_cmd(make_cmd(OP_APPEND, 5'd1,  1'b0, 2'd0, 16'h5A5A, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b0, 2'd0, 16'h0000, 5'sd0));
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b0, 2'd0, 16'h0000, 5'sd0));
    // owner numbers outside one to OWNERS count as absent
    send_cmd(make_cmd(OP_APPEND, 5'd0,  1'b1, 2'd0, 16'hA5A5, 5'sd0));
    send_cmd(make_cmd(OP_APPEND, 5'd17, 1'b1, 2'd0, 16'hA5A5, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd31, 1'b1, 2'd3, 16'hA5A5, 5'sd0));
    send_cmd(make_cmd(OP_UNDEF,  5'd1,  1'b1, 2'd0, 16'h0000, 5'sd0));
    // negative, at-count and far-past-count positions are rejected
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b1, 2'd0, 16'h0000, -5'sd1));
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b1, 2'd0, 16'h0000, -5'sd16));
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b1, 2'd0, 16'h0000, 5'sd3));
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b1, 2'd0, 16'h0000, 5'sd15));
    // drop the head, check the shift, then drop the tail
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b1, 2'd0, 16'h0000, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b1, 2'd0, 16'h0000, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b1, 2'd0, 16'hFFFF, 5'sd0));
    send_cmd(make_cmd(OP_REMOVE, 5'd1,  1'b1, 2'd0, 16'h0000, 5'sd1));
    send_cmd(make_cmd(OP_FIND,   5'd1,  1'b1, 2'd0, 16'hFFFF, 5'sd0));
  endtask

  // Fill the highest owner's last list to the brim, overflow it and find its last value,
  // then remove from the tail and the middle and try one position past the count and one at it.
  task automatic test_full_list();
    int k;
    for (k = 0; k < SLOTS; k++) begin
      send_cmd(make_cmd(OP_APPEND, 5'd16, 1'b1, 2'd3, 16'($urandom_range(0, 65535)), 5'sd0));
    end
    send_cmd(make_cmd(OP_APPEND, 5'd16, 1'b1, 2'd3, 16'h7777, 5'sd0));
    send_cmd(make_cmd(OP_FIND,   5'd16, 1'b1, 2'd3, list_vals[LISTS-1][SLOTS-1], 5'sd0));
    send_cmd(make_cmd(OP_REMOVE, 5'd16, 1'b1, 2'd3, 16'h0000, 5'sd15));
    send_cmd(make_cmd(OP_REMOVE, 5'd16, 1'b1, 2'd3, 16'h0000, 5'sd7));
    send_cmd(make_cmd(OP_REMOVE, 5'd16, 1'b1, 2'd3, 16'h0000, 5'sd15));
    send_cmd(make_cmd(OP_REMOVE, 5'd16, 1'b1, 2'd3, 16'h0000, 5'sd14));
    send_cmd(make_cmd(OP_APPEND, 5'd16, 1'b1, 2'd3, 16'h8001, 5'sd0));
  endtask

  // Random words aimed mostly at a few hot lists so that they fill, overflow
  // and drain. append_pct sets how often a word is an append; the rest splits
  // between find and remove, with a trickle of undefined op codes. A little
  // noise goes to absent and out-of-range owners.
  task automatic test_random_traffic(input int count, input int append_pct);
    list_cmd_t c;
    int        k;
    int        li;
    int        n;
    int        r;
    int        lo;
    for (k = 0; k < count; k++) begin
      li = ($urandom_range(0, 99) < 80) ? hot_list[$urandom_range(0, 3)]
                                        : $urandom_range(0, LISTS - 1);
      n         = list_count[li];
      c.owner   = OWNER_W'(li / CATEGORIES + 1);
      c.cat     = CAT_W'(li % CATEGORIES);
      c.present = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        c.present = 1'b0;
      end else if (r < 5) begin
        c.owner = OWNER_W'($urandom_range(OWNERS + 1, 31));
      end else if (r < 6) begin
        c.owner = '0;
      end
      r = $urandom_range(0, 99);
      if (r < append_pct) begin
        c.op = OP_APPEND;
      end else if (r < append_pct + (97 - append_pct) / 2) begin
        c.op = OP_FIND;
      end else if (r < 97) begin
        c.op = OP_REMOVE;
      end else begin
        c.op = OP_UNDEF;
      end
      // small values repeat often, so find meets duplicates
      c.value = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
                                     : 16'($urandom_range(0, 65535));
      if (c.op == OP_FIND && n > 0 && $urandom_range(0, 99) < 60) begin
        c.value = list_vals[li][$urandom_range(0, n - 1)];
      end
      r = $urandom_range(0, 99);
      if (c.op != OP_REMOVE) begin
        c.pos = POS_W'($urandom_range(0, 31));
      end else if (n > 0 && r < 75) begin
        c.pos = POS_W'($urandom_range(0, n - 1));
      end else if (r < 88) begin
        lo    = (n > 15) ? 15 : n;
        c.pos = POS_W'($urandom_range(lo, 15));
      end else begin
        lo    = $urandom_range(1, 16);
        c.pos = POS_W'(-lo);
      end
      send_cmd(c);
    end
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // output register fills and the core stalls its command side.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    test_random_traffic(8, 50);
  endtask

  // Drop valid, wait for every answer owed, allow the pipeline to settle, report.
  task automatic finish_run();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("multi_list_append_search_remove_core_tb: PASS");
    end else begin
      $display("multi_list_append_search_remove_core_tb: FAIL");
    end
    $finish;
  endtask

  initial begin
    // hold every input at a known value from time zero
    rst                  = 1'b1;
    cmd_ch.valid         = 1'b0;
    cmd_ch.op            = OP_APPEND;
    cmd_ch.owner_id      = '0;
    cmd_ch.owner_present = 1'b0;
    cmd_ch.category      = '0;
    cmd_ch.item_value    = '0;
    cmd_ch.position      = '0;
    error_count          = 0;
    cycle_count          = 0;
    idle_on              = 1'b1;
    hold_request         = 1'b0;
    foreach (list_count[i]) list_count[i] = 0;
    foreach (hot_list[i]) hot_list[i] = $urandom_range(0, LISTS - 1);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // the core clears its counts after reset; send_cmd simply waits on ready
    test_edge_cases();
    test_full_list();
    test_random_traffic(350, 65);
    test_output_backpressure();
    test_random_traffic(350, 20);
    test_random_traffic(350, 45);
    // last stretch runs flat out on both sides
    idle_on = 1'b0;
    test_random_traffic(400, 40);
    finish_run();
  end

endmodule
